### hw/rtl/overcurrent_relay_autoreclose_defines.svh
// ---------------------------------------------------------------------------
// Overcurrent relay assertion macros
// Shared assertion forms for the relay; clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef OVERCURRENT_RELAY_AUTORECLOSE_DEFINES_SVH
`define OVERCURRENT_RELAY_AUTORECLOSE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ORAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ORAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/orac_pkg.sv
// ---------------------------------------------------------------------------
// Overcurrent relay package
// Widths, constants, register indexes and shared types of the relay.
// ---------------------------------------------------------------------------
package orac_pkg;

    localparam int TICK_BITS_DEF = 32;

    localparam int CUR_W     = 20;
    localparam int LIMIT_W   = 20;
    localparam int DELAY_W   = 16;
    localparam int LOAD_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECLOSE_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECLOSE_COOLDOWN = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 20'd16000;
    localparam logic [DELAY_W-1:0] DELAY_RESET    = 16'd1500;
    localparam logic [DELAY_W-1:0] COOLDOWN_RESET = 16'd800;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN      = 20'd16;

    localparam logic [DELAY_W-1:0] MAX_TRIP_DELAY = 16'd5000;

    // Scale factors of the loading and trip-time arithmetic.
    localparam int LOAD_SCALE   = 10000;
    localparam int DELAY_SCALE  = 8400;
    localparam int PICKUP_CUR   = 20;
    localparam int PICKUP_LIMIT = 21;

    // Shared divider: 34-bit dividend, 25-bit divisor, 16-bit quotient.
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 25;
    localparam int DIV_Q_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_RECL,
        ST_LDIV,
        ST_LWAIT,
        ST_PICK,
        ST_DWAIT,
        ST_TRIP,
        ST_DONE
    } orac_state_t;

endpackage

### hw/rtl/orac_if.sv
// ---------------------------------------------------------------------------
// Overcurrent relay channel interfaces
// Measurement, result and configuration channels with valid/ready.
// ---------------------------------------------------------------------------
interface orac_meas_if;
    logic                       valid;
    logic                       ready;
    logic [orac_pkg::CUR_W-1:0] current_mag;
    logic                       breaker_open;

    modport source (output valid, current_mag, breaker_open, input ready);
    modport sink   (input valid, current_mag, breaker_open, output ready);
endinterface

interface orac_result_if;
    logic                        valid;
    logic                        ready;
    logic                        trip_cmd;
    logic                        close_cmd;
    logic                        overload_active;
    logic [orac_pkg::LOAD_W-1:0] loading_centi_pct;
    logic [orac_pkg::LOAD_W-1:0] peak_loading_centi_pct;

    modport source (output valid, trip_cmd, close_cmd, overload_active,
                    loading_centi_pct, peak_loading_centi_pct, input ready);
    modport sink   (input valid, trip_cmd, close_cmd, overload_active,
                    loading_centi_pct, peak_loading_centi_pct, output ready);
endinterface

interface orac_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [orac_pkg::CFG_IDX_W-1:0]  addr;
    logic [orac_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

### hw/rtl/orac_div.sv
// ---------------------------------------------------------------------------
// Overcurrent relay serial divider
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// ---------------------------------------------------------------------------
module orac_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  orac_pkg::div_req_t req,
    output orac_pkg::div_rsp_t rsp
);

    localparam int NUM_W = orac_pkg::DIV_NUM_W;
    localparam int DEN_W = orac_pkg::DIV_DEN_W;
    localparam int Q_W   = orac_pkg::DIV_Q_W;
    localparam int CNT_W = orac_pkg::DIV_CNT_W;
    localparam int HI_W  = NUM_W - Q_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   low_reg, low_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             sat_reg, sat_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [HI_W-1:0]  hi;

    assign trial = {rem_reg, low_reg[Q_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign hi    = req.num[NUM_W-1:Q_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        sat_next  = sat_reg;
        if (req.start)
        begin
            // The quotient overflows 16 bits exactly when the upper dividend
            // bits already reach the divisor.
            rem_next  = DEN_W'(hi);
            low_next  = req.num[Q_W-1:0];
            den_next  = req.den;
            sat_next  = (DEN_W'(hi) >= req.den);
            cnt_next  = CNT_W'(Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next  = {low_reg[Q_W-2:0], 1'b0};
            quot_next = {quot_reg[Q_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        sat_reg  <= sat_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quot = quot_reg;

endmodule

### hw/rtl/overcurrent_relay_autoreclose.sv
// ---------------------------------------------------------------------------
// Overcurrent relay with automatic reclose
// Inverse-time overcurrent protection of one line, with loading report and
// a single-shot reclose of the breaker after each trip.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Carries                         Transfer when
//  -------  ---------  ------------------------------  ----------------------
//  meas     in         one protection tick             meas.valid & ready
//  result   out        commands and loading of a tick  result.valid & ready
//  cfg      in         register index and write data   cfg.valid & ready
//
//  A tick passes the sequencer steps TICK, RECL, LDIV, LWAIT, PICK, DWAIT,
//  TRIP and DONE, with two passes of the shared serial divider (16 quotient
//  bits each, one per cycle) in LWAIT and DWAIT. A tick below pickup skips
//  the second pass and goes from PICK straight to DONE. A finished
//  result waits in the output register, so the next tick may be taken
//  meanwhile; the sequencer stalls only if a new result is ready while the
//  old one is still untaken. The configuration port always accepts. Reset is
//  asynchronous and clears the timers, flags and peak loading, and restores
//  register defaults.
//
module overcurrent_relay_autoreclose
#(
    parameter int TICK_BITS = orac_pkg::TICK_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    orac_meas_if.sink     meas,
    orac_result_if.source result,
    orac_cfg_if.sink      cfg
);

    `include "overcurrent_relay_autoreclose_defines.svh"

    localparam int CUR_W   = orac_pkg::CUR_W;
    localparam int LIMIT_W = orac_pkg::LIMIT_W;
    localparam int DELAY_W = orac_pkg::DELAY_W;
    localparam int LOAD_W  = orac_pkg::LOAD_W;
    localparam int NUM_W   = orac_pkg::DIV_NUM_W;
    localparam int DEN_W   = orac_pkg::DIV_DEN_W;

    // Saturating sum of a tick value and a 16-bit interval.
    function automatic logic [TICK_BITS-1:0] tick_add
    (
        input logic [TICK_BITS-1:0] a,
        input logic [DELAY_W-1:0]   b
    );
        logic [TICK_BITS:0] s;
        s = {1'b0, a} + {{(TICK_BITS+1-DELAY_W){1'b0}}, b};
        return s[TICK_BITS] ? {TICK_BITS{1'b1}} : s[TICK_BITS-1:0];
    endfunction

    // Sequencer and per-tick working registers.
    orac_pkg::orac_state_t state_reg, state_next;
    logic [CUR_W-1:0]     cur_reg, cur_next;
    logic                 open_reg, open_next;
    logic [LIMIT_W-1:0]   lim_reg, lim_next;
    logic                 trip_reg, trip_next;
    logic                 close_reg, close_next;
    logic [LOAD_W-1:0]    load_reg, load_next;
    logic [TICK_BITS-1:0] trip_due_reg, trip_due_next;

    // Relay state kept from tick to tick.
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic                 rcl_pend_reg, rcl_pend_next;
    logic [TICK_BITS-1:0] rcl_due_reg, rcl_due_next;
    logic                 cool_valid_reg, cool_valid_next;
    logic [TICK_BITS-1:0] cool_end_reg, cool_end_next;
    logic                 ovl_flag_reg, ovl_flag_next;
    logic [TICK_BITS-1:0] ovl_start_reg, ovl_start_next;
    logic [LOAD_W-1:0]    peak_reg, peak_next;

    // Configuration registers.
    logic [LIMIT_W-1:0] cur_limit_reg, cur_limit_next;
    logic [DELAY_W-1:0] rcl_delay_reg, rcl_delay_next;
    logic [DELAY_W-1:0] rcl_cool_reg, rcl_cool_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic              out_trip_reg, out_trip_next;
    logic              out_close_reg, out_close_next;
    logic              out_ovl_reg, out_ovl_next;
    logic [LOAD_W-1:0] out_load_reg, out_load_next;
    logic [LOAD_W-1:0] out_peak_reg, out_peak_next;

    orac_pkg::div_req_t div_req;
    orac_pkg::div_rsp_t div_rsp;
    logic               div_start;

    logic [LIMIT_W-1:0] eff_lim;
    logic [NUM_W-1:0]   load_num;
    logic [NUM_W-1:0]   dly_num;
    logic [DEN_W-1:0]   cur_scaled;
    logic [DEN_W-1:0]   lim_scaled;
    logic [DEN_W-1:0]   excess;
    logic               pick_hit;
    logic [LOAD_W-1:0]  load_val;
    logic [DELAY_W-1:0] dly_val;

    // Terms watched by the checks at the end of the module.
    logic               meas_xfer;
    logic               in_tick;
    logic               in_wait;
    logic               in_done;
    logic               peak_ge_load;

    // A limit below LIMIT_MIN (16) counts as LIMIT_MIN.
    assign eff_lim = (cur_limit_reg < orac_pkg::LIMIT_MIN) ? orac_pkg::LIMIT_MIN
                                                           : cur_limit_reg;

    // Constant products: loading dividend, pickup compare and trip-time terms.
    assign load_num   = NUM_W'(cur_reg) * NUM_W'(orac_pkg::LOAD_SCALE);
    assign dly_num    = NUM_W'(lim_reg) * NUM_W'(orac_pkg::DELAY_SCALE);
    assign cur_scaled = DEN_W'(cur_reg) * DEN_W'(orac_pkg::PICKUP_CUR);
    assign lim_scaled = DEN_W'(lim_reg) * DEN_W'(orac_pkg::PICKUP_LIMIT);
    assign pick_hit   = (cur_scaled > lim_scaled);
    assign excess     = cur_scaled - lim_scaled;

    // The divider serves the loading first and the trip time second.
    assign div_req.start = div_start;
    assign div_req.num   = (state_reg == orac_pkg::ST_LDIV) ? load_num : dly_num;
    assign div_req.den   = (state_reg == orac_pkg::ST_LDIV) ? DEN_W'(lim_reg) : excess;

    assign load_val = div_rsp.sat ? {LOAD_W{1'b1}} : div_rsp.quot;
    assign dly_val  = (div_rsp.sat || (div_rsp.quot > orac_pkg::MAX_TRIP_DELAY))
                      ? orac_pkg::MAX_TRIP_DELAY : div_rsp.quot;

    orac_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        open_next       = open_reg;
        lim_next        = lim_reg;
        trip_next       = trip_reg;
        close_next      = close_reg;
        load_next       = load_reg;
        trip_due_next   = trip_due_reg;
        tick_next       = tick_reg;
        rcl_pend_next   = rcl_pend_reg;
        rcl_due_next    = rcl_due_reg;
        cool_valid_next = cool_valid_reg;
        cool_end_next   = cool_end_reg;
        ovl_flag_next   = ovl_flag_reg;
        ovl_start_next  = ovl_start_reg;
        peak_next       = peak_reg;
        cur_limit_next  = cur_limit_reg;
        rcl_delay_next  = rcl_delay_reg;
        rcl_cool_next   = rcl_cool_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_trip_next   = out_trip_reg;
        out_close_next  = out_close_reg;
        out_ovl_next    = out_ovl_reg;
        out_load_next   = out_load_reg;
        out_peak_next   = out_peak_reg;
        div_start       = 1'b0;

        // Writes to an index beyond the three registers are dropped.
        if (cfg.valid)
        begin
            case (cfg.addr)
                orac_pkg::REG_CURRENT_LIMIT:    cur_limit_next = cfg.data;
                orac_pkg::REG_RECLOSE_DELAY:    rcl_delay_next = cfg.data[DELAY_W-1:0];
                orac_pkg::REG_RECLOSE_COOLDOWN: rcl_cool_next  = cfg.data[DELAY_W-1:0];
                default:                        ;
            endcase
        end

        case (state_reg)
            orac_pkg::ST_IDLE:
            begin
                if (meas.valid)
                begin
                    cur_next   = meas.current_mag;
                    open_next  = meas.breaker_open;
                    lim_next   = eff_lim;
                    trip_next  = 1'b0;
                    close_next = 1'b0;
                    state_next = orac_pkg::ST_TICK;
                end
            end
            orac_pkg::ST_TICK:
            begin
                tick_next  = tick_add(tick_reg, DELAY_W'(1));
                state_next = orac_pkg::ST_RECL;
            end
            orac_pkg::ST_RECL:
            begin
                // A due reclose is consumed whether or not it closes the
                // breaker; after a close the breaker counts as closed.
                if (rcl_pend_reg && (rcl_due_reg <= tick_reg))
                begin
                    if (!(cool_valid_reg && (tick_reg < cool_end_reg)) && open_reg)
                    begin
                        open_next       = 1'b0;
                        close_next      = 1'b1;
                        cool_end_next   = tick_add(tick_reg, rcl_cool_reg);
                        cool_valid_next = 1'b1;
                    end
                    rcl_pend_next = 1'b0;
                end
                state_next = orac_pkg::ST_LDIV;
            end
            orac_pkg::ST_LDIV:
            begin
                div_start  = 1'b1;
                state_next = orac_pkg::ST_LWAIT;
            end
            orac_pkg::ST_LWAIT:
            begin
                if (div_rsp.done)
                begin
                    load_next = load_val;
                    if (load_val > peak_reg)
                    begin
                        peak_next = load_val;
                    end
                    state_next = orac_pkg::ST_PICK;
                end
            end
            orac_pkg::ST_PICK:
            begin
                if (pick_hit)
                begin
                    div_start  = 1'b1;
                    state_next = orac_pkg::ST_DWAIT;
                end
                else
                begin
                    // Below pickup the overload timer drops out.
                    ovl_flag_next = 1'b0;
                    state_next    = orac_pkg::ST_DONE;
                end
            end
            orac_pkg::ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!ovl_flag_reg)
                    begin
                        ovl_flag_next  = 1'b1;
                        ovl_start_next = tick_reg;
                        trip_due_next  = tick_add(tick_reg, dly_val);
                    end
                    else
                    begin
                        trip_due_next = tick_add(ovl_start_reg, dly_val);
                    end
                    state_next = orac_pkg::ST_TRIP;
                end
            end
            orac_pkg::ST_TRIP:
            begin
                // A due trip only acts on a closed breaker, and arms a reclose.
                if ((trip_due_reg <= tick_reg) && !open_reg)
                begin
                    trip_next     = 1'b1;
                    rcl_pend_next = 1'b1;
                    rcl_due_next  = tick_add(tick_reg, rcl_delay_reg);
                end
                state_next = orac_pkg::ST_DONE;
            end
            orac_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_trip_next  = trip_reg;
                    out_close_next = close_reg;
                    out_ovl_next   = ovl_flag_reg;
                    out_load_next  = load_reg;
                    out_peak_next  = peak_reg;
                    state_next     = orac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = orac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= orac_pkg::ST_IDLE;
            tick_reg       <= '0;
            rcl_pend_reg   <= 1'b0;
            rcl_due_reg    <= '0;
            cool_valid_reg <= 1'b0;
            cool_end_reg   <= '0;
            ovl_flag_reg   <= 1'b0;
            ovl_start_reg  <= '0;
            peak_reg       <= '0;
            cur_limit_reg  <= orac_pkg::LIMIT_RESET;
            rcl_delay_reg  <= orac_pkg::DELAY_RESET;
            rcl_cool_reg   <= orac_pkg::COOLDOWN_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            rcl_pend_reg   <= rcl_pend_next;
            rcl_due_reg    <= rcl_due_next;
            cool_valid_reg <= cool_valid_next;
            cool_end_reg   <= cool_end_next;
            ovl_flag_reg   <= ovl_flag_next;
            ovl_start_reg  <= ovl_start_next;
            peak_reg       <= peak_next;
            cur_limit_reg  <= cur_limit_next;
            rcl_delay_reg  <= rcl_delay_next;
            rcl_cool_reg   <= rcl_cool_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        open_reg      <= open_next;
        lim_reg       <= lim_next;
        trip_reg      <= trip_next;
        close_reg     <= close_next;
        load_reg      <= load_next;
        trip_due_reg  <= trip_due_next;
        out_trip_reg  <= out_trip_next;
        out_close_reg <= out_close_next;
        out_ovl_reg   <= out_ovl_next;
        out_load_reg  <= out_load_next;
        out_peak_reg  <= out_peak_next;
    end

    assign meas.ready = (state_reg == orac_pkg::ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid                  = out_valid_reg;
    assign result.trip_cmd               = out_trip_reg;
    assign result.close_cmd              = out_close_reg;
    assign result.overload_active        = out_ovl_reg;
    assign result.loading_centi_pct      = out_load_reg;
    assign result.peak_loading_centi_pct = out_peak_reg;

    assign meas_xfer    = meas.valid && meas.ready;
    assign in_tick      = (state_reg == orac_pkg::ST_TICK);
    assign in_wait      = (state_reg == orac_pkg::ST_LWAIT) || (state_reg == orac_pkg::ST_DWAIT);
    assign in_done      = (state_reg == orac_pkg::ST_DONE);
    assign peak_ge_load = (result.peak_loading_centi_pct >= result.loading_centi_pct);

    // A taken tick starts the sequencer, and that closes the input.
    `ORAC_ASSERT_NEXT(a_accept_starts, meas_xfer, in_tick && !meas.ready, "tick not started")
    // The divider only finishes while the sequencer waits for it.
    `ORAC_ASSERT_SAME(a_div_done_waited, div_rsp.done, in_wait, "divider done outside a wait")
    // A new result only appears when the sequencer hands one over.
    `ORAC_ASSERT_SAME(a_result_source, $rose(result.valid), $past(in_done), "result without a tick")
    // The reported peak never lies below the loading it is reported with.
    `ORAC_ASSERT_SAME(a_peak_covers_load, result.valid, peak_ge_load, "peak below loading")

endmodule
